// ----- rtl/core/sgli_pkg.sv -----
// ---------------------------------------------------------------------------
// sgli_pkg
// Shared types and constants for the sorted grid lookup interpolator.
// ---------------------------------------------------------------------------
package sgli_pkg;

    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE  = 1'b1;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef enum logic [3:0] {
        t_ST_IDLE,
        t_ST_FIRST,
        t_ST_LAST,
        t_ST_SEARCH,
        t_ST_LO,
        t_ST_HI,
        t_ST_PREP,
        t_ST_DIV,
        t_ST_MUL,
        t_ST_TOL,
        t_ST_DONE,
        t_ST_OUT
    } t_state;

    // Address source for the table read port
    typedef enum logic [2:0] {
        t_ADDR_FIRST,
        t_ADDR_LAST,
        t_ADDR_MID,
        t_ADDR_LO,
        t_ADDR_HI
    } t_addr_sel;

    // Controller to datapath commands
    typedef struct packed {
        logic      load_query;
        logic      rd_en;
        t_addr_sel addr_sel;
        logic      cap_first;
        logic      cap_last;
        logic      search_step;
        logic      cap_lo;
        logic      cap_hi;
        logic      prep;
        logic      div_step;
        logic      mul;
        logic      tol;
        logic      finish;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic search_done;
        logic div_done;
    } t_status;

endpackage

// ----- rtl/core/sorted_grid_lookup_interpolator_core.sv -----
// Query path from acceptance to result valid: two endpoint reads, a binary search whose
// read count is set by node_count, two neighbor reads, setup, a restoring divide,
// multiply, tolerance compare and result register.
// Throughput: one item at a time; a query holds the input until its result is taken,
// a load is accepted whenever the block is idle.
// Reset (synchronous, active low) clears control, node_count=3, tolerance=0; tables kept.
// ---------------------------------------------------------------------------
// sorted_grid_lookup_interpolator_core
// Nonuniform piecewise linear table lookup with nearest node and hit flag.
// ---------------------------------------------------------------------------
module sorted_grid_lookup_interpolator_core
    import sgli_pkg::*;
#(
    parameter int unsigned MAX_NODES = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // tdata: node_index[7:0], node_position[39:8], node_value[71:40], query_point[103:72]
    input  logic [103:0]         s_axis_tdata,
    // tuser: kind
    input  logic                 s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // tdata: nearest_index[7:0], interpolated_value[39:8], node_hit[40], pad
    output logic [47:0]          m_axis_tdata,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int unsigned AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int unsigned NW = $clog2(MAX_NODES + 1);

    logic [8:0]  r_node_count;
    logic [31:0] r_tol;
    logic [NW-1:0] n_active;
    t_cmd cmd;
    t_status status;
    logic idle, out_valid, start;
    logic [7:0] near;
    logic [31:0] value;
    logic hit;

    // Hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= 9'd3;
            r_tol <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_NODE_COUNT: r_node_count <= i_cfg_data[8:0];
                CFG_TOLERANCE:  r_tol <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp node count into range
    always_comb begin
        if (r_node_count < 9'd3) begin
            n_active = NW'(3);
        end else if (32'(r_node_count) > 32'(MAX_NODES)) begin
            n_active = NW'(MAX_NODES);
        end else begin
            n_active = NW'(r_node_count);
        end
    end

    assign s_axis_tready = idle;
    assign start = s_axis_tvalid && idle && (s_axis_tuser == KIND_QUERY);

    sgli_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_out_taken(m_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_idle     (idle),
        .o_out_valid(out_valid)
    );

    sgli_datapath #(.MAX_NODES(MAX_NODES), .AW(AW), .NW(NW)) u_dp (
        .i_clk       (i_clk),
        .i_load_en   (s_axis_tvalid && idle && (s_axis_tuser == KIND_LOAD)),
        .i_load_index(s_axis_tdata[7:0]),
        .i_load_pos  (s_axis_tdata[39:8]),
        .i_load_val  (s_axis_tdata[71:40]),
        .i_query     (s_axis_tdata[103:72]),
        .i_n         (n_active),
        .i_tol       (r_tol),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_nearest   (near),
        .o_value     (value),
        .o_hit       (hit)
    );

    assign m_axis_tvalid = out_valid;
    assign m_axis_tdata = {7'd0, hit, value, near};

    // Never accept an item while a result waits
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input accepted while result pending");

    // An accepted query leaves the block busy and not ready
    a_result_after_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser == KIND_QUERY) |=> !s_axis_tready)
        else $error("query did not occupy the block");

    // A delivered result returns the block to idle
    a_idle_after_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready) |=> s_axis_tready)
        else $error("block not idle after result");

endmodule

// ----- rtl/core/sgli_ctrl.sv -----
// ---------------------------------------------------------------------------
// sgli_ctrl
// Query sequencer: endpoint reads, binary search, neighbor reads, divide, multiply, tolerance, output.
// ---------------------------------------------------------------------------
module sgli_ctrl
    import sgli_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  logic    i_out_taken,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_idle,
    output logic    o_out_valid
);

    t_state r_state;
    t_state n_state;

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= t_ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Advance state and drive commands
    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_cmd.addr_sel = t_ADDR_FIRST;
        o_idle = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            t_ST_IDLE: begin
                o_idle = 1'b1;
                if (i_start) begin
                    o_cmd.load_query = 1'b1;
                    o_cmd.rd_en = 1'b1;
                    o_cmd.addr_sel = t_ADDR_FIRST;
                    n_state = t_ST_FIRST;
                end
            end
            t_ST_FIRST: begin
                o_cmd.cap_first = 1'b1;
                o_cmd.rd_en = 1'b1;
                o_cmd.addr_sel = t_ADDR_LAST;
                n_state = t_ST_LAST;
            end
            t_ST_LAST: begin
                o_cmd.cap_last = 1'b1;
                o_cmd.rd_en = 1'b1;
                o_cmd.addr_sel = t_ADDR_MID;
                n_state = t_ST_SEARCH;
            end
            t_ST_SEARCH: begin
                o_cmd.search_step = 1'b1;
                o_cmd.rd_en = 1'b1;
                if (i_status.search_done) begin
                    o_cmd.addr_sel = t_ADDR_LO;
                    n_state = t_ST_LO;
                end else begin
                    o_cmd.addr_sel = t_ADDR_MID;
                end
            end
            t_ST_LO: begin
                o_cmd.cap_lo = 1'b1;
                o_cmd.rd_en = 1'b1;
                o_cmd.addr_sel = t_ADDR_HI;
                n_state = t_ST_HI;
            end
            t_ST_HI: begin
                o_cmd.cap_hi = 1'b1;
                n_state = t_ST_PREP;
            end
            t_ST_PREP: begin
                o_cmd.prep = 1'b1;
                n_state = t_ST_DIV;
            end
            t_ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_done) begin
                    n_state = t_ST_MUL;
                end
            end
            t_ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = t_ST_TOL;
            end
            t_ST_TOL: begin
                o_cmd.tol = 1'b1;
                n_state = t_ST_DONE;
            end
            t_ST_DONE: begin
                o_cmd.finish = 1'b1;
                n_state = t_ST_OUT;
            end
            t_ST_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_taken) begin
                    n_state = t_ST_IDLE;
                end
            end
            default: n_state = t_ST_IDLE;
        endcase
    end

endmodule

// ----- rtl/core/sgli_datapath.sv -----
// ---------------------------------------------------------------------------
// sgli_datapath
// Node tables, search registers, serial divider and result arithmetic.
// ---------------------------------------------------------------------------
module sgli_datapath
    import sgli_pkg::*;
#(
    parameter int unsigned MAX_NODES = 256,
    parameter int unsigned AW = 8,
    parameter int unsigned NW = 9
) (
    input  logic          i_clk,
    input  logic          i_load_en,
    input  logic [7:0]    i_load_index,
    input  logic [31:0]   i_load_pos,
    input  logic [31:0]   i_load_val,
    input  logic [31:0]   i_query,
    input  logic [NW-1:0] i_n,
    input  logic [31:0]   i_tol,
    input  t_cmd          i_cmd,
    output t_status       o_status,
    output logic [7:0]    o_nearest,
    output logic [31:0]   o_value,
    output logic          o_hit
);

    // Result source for the interpolated value
    localparam logic [1:0] MODE_INTERP = 2'd0;
    localparam logic [1:0] MODE_LO     = 2'd1;
    localparam logic [1:0] MODE_HI     = 2'd2;

    logic [31:0] r_pos_mem [MAX_NODES];
    logic [31:0] r_val_mem [MAX_NODES];
    logic [31:0] r_rd_pos;
    logic [31:0] r_rd_val;
    logic [AW-1:0] n_addr;

    logic signed [31:0] r_s;
    logic [NW-1:0] r_first;
    logic [NW-1:0] r_count;
    logic [NW-1:0] r_mid;
    logic signed [31:0] r_p0, r_v0, r_pl, r_vl;
    logic signed [31:0] r_plo, r_vlo, r_phi, r_vhi;
    logic [1:0] r_mode;
    logic [32:0] r_den;
    logic [32:0] r_rem;
    logic [31:0] r_q;
    logic [5:0] r_div_cnt;
    logic [32:0] r_dmag;
    logic r_dneg;
    logic [64:0] r_prod;
    logic [NW-1:0] r_near;
    logic [32:0] r_dist;
    logic [32:0] r_smag;
    logic [31:0] r_res_v;
    logic [7:0]  r_res_i;
    logic r_res_h;
    logic [63:0] r_lhs;
    logic [64:0] r_rhs;

    logic [NW-1:0] half;
    logic [NW-1:0] mid;
    logic [NW:0]   nxt_cnt;
    logic          go_right;
    logic [NW-1:0] n_first;

    // Select table read address
    always_comb begin
        case (i_cmd.addr_sel)
            t_ADDR_FIRST: n_addr = '0;
            t_ADDR_LAST:  n_addr = AW'(i_n - NW'(1));
            t_ADDR_MID:   n_addr = AW'(mid);
            t_ADDR_LO:    n_addr = AW'(n_first - NW'(1));
            default:      n_addr = AW'(r_first);
        endcase
    end

    // Write and read the node tables
    always_ff @(posedge i_clk) begin
        if (i_load_en && (32'(i_load_index) < 32'(MAX_NODES))) begin
            r_pos_mem[AW'(i_load_index)] <= i_load_pos;
            r_val_mem[AW'(i_load_index)] <= i_load_val;
        end
        if (i_cmd.rd_en) begin
            r_rd_pos <= r_pos_mem[n_addr];
            r_rd_val <= r_val_mem[n_addr];
        end
    end

    assign half = r_count >> 1;
    assign mid = i_cmd.load_query ? (i_n >> 1)
               : (i_cmd.search_step ? n_first + (nxt_cnt[NW-1:0] >> 1) : r_first + half);

    // Next search window after the current compare
    assign go_right = $signed(r_rd_pos) < r_s;
    assign n_first = go_right ? r_mid + NW'(1) : r_first;
    assign nxt_cnt = go_right ? {1'b0, r_count - half - NW'(1)} : {1'b0, half};
    assign o_status.search_done = (nxt_cnt == '0);
    assign o_status.div_done = (r_div_cnt == 6'd31);

    logic signed [32:0] num, den;
    assign num = 33'(r_s) - 33'(r_plo);
    assign den = 33'(r_phi) - 33'(r_plo);

    logic [33:0] trial;
    assign trial = {r_rem, r_q[31]} - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_query) begin
            r_s <= $signed(i_query);
            r_first <= '0;
            r_count <= i_n;
            r_mid <= i_n >> 1;
        end
        if (i_cmd.cap_first) begin
            r_p0 <= r_rd_pos;
            r_v0 <= r_rd_val;
        end
        if (i_cmd.cap_last) begin
            r_pl <= r_rd_pos;
            r_vl <= r_rd_val;
        end
        // Binary search step on the registered read
        if (i_cmd.search_step) begin
            r_first <= n_first;
            r_count <= nxt_cnt[NW-1:0];
            r_mid <= n_first + (nxt_cnt[NW-1:0] >> 1);
        end
        if (i_cmd.cap_lo) begin
            r_plo <= r_rd_pos;
            r_vlo <= r_rd_val;
        end
        if (i_cmd.cap_hi) begin
            r_phi <= r_rd_pos;
            r_vhi <= r_rd_val;
        end
        // Pick the neighbor and set up the divide
        if (i_cmd.prep) begin
            if (r_s <= r_p0) begin
                r_mode <= MODE_LO; r_vlo <= r_v0;
            end else if (r_s >= r_pl) begin
                r_mode <= MODE_LO; r_vlo <= r_vl;
            end else if (r_first == '0) begin
                r_mode <= MODE_LO; r_vlo <= r_v0;
            end else if (r_first >= i_n) begin
                r_mode <= MODE_LO; r_vlo <= r_vl;
            end else if (den <= 0 || num < 0) begin
                r_mode <= MODE_LO;
            end else if (num >= den) begin
                r_mode <= MODE_HI;
            end else begin
                r_mode <= MODE_INTERP;
            end
            r_den <= den[32:0];
            r_rem <= num[32:0];
            r_q <= '0;
            r_div_cnt <= '0;
            r_dmag <= (r_vhi < r_vlo) ? 33'(r_vlo) - 33'(r_vhi) : 33'(r_vhi) - 33'(r_vlo);
            r_dneg <= r_vhi < r_vlo;
            // nearest index
            if (r_first == '0) begin
                r_near <= '0;
            end else if (r_first >= i_n) begin
                r_near <= i_n - NW'(1);
            end else if (33'(r_s) - 33'(r_plo) <= 33'(r_phi) - 33'(r_s)) begin
                r_near <= r_first - NW'(1);
            end else begin
                r_near <= r_first;
            end
        end
        // Restoring divide, one quotient bit a cycle (numerator shifted by 32)
        if (i_cmd.div_step) begin
            if (!trial[33]) begin
                r_rem <= trial[32:0];
                r_q <= {r_q[30:0], 1'b1};
            end else begin
                r_rem <= {r_rem[31:0], 1'b0};
                r_q <= {r_q[30:0], 1'b0};
            end
            r_div_cnt <= r_div_cnt + 6'd1;
        end
        if (i_cmd.mul) begin
            r_prod <= 65'(r_dmag) * 65'(r_q) + 65'h80000000;
            // Distance to the nearest node
            if (r_first == '0) begin
                r_dist <= (r_p0 >= r_s) ? 33'(r_p0) - 33'(r_s) : 33'(r_s) - 33'(r_p0);
            end else if (r_first >= i_n) begin
                r_dist <= (r_pl >= r_s) ? 33'(r_pl) - 33'(r_s) : 33'(r_s) - 33'(r_pl);
            end else if (r_near == r_first) begin
                r_dist <= (r_phi >= r_s) ? 33'(r_phi) - 33'(r_s) : 33'(r_s) - 33'(r_phi);
            end else begin
                r_dist <= 33'(r_s) - 33'(r_plo);
            end
            r_smag <= r_s[31] ? 33'd0 - 33'(r_s) : 33'(r_s);
        end
        if (i_cmd.tol) begin
            r_lhs <= {15'd0, r_dist, 16'd0};
            r_rhs <= 65'(i_tol) * ((r_smag > 33'd65536) ? 65'(r_smag) : 65'd65536);
        end
        if (i_cmd.finish) begin
            r_res_i <= r_near[7:0];
            r_res_h <= 65'(r_lhs) <= r_rhs;
            case (r_mode)
                MODE_LO: r_res_v <= r_vlo;
                MODE_HI: r_res_v <= r_vhi;
                default: r_res_v <= r_dneg ? r_vlo - r_prod[63:32] : r_vlo + r_prod[63:32];
            endcase
        end
    end

    assign o_nearest = r_res_i;
    assign o_value = r_res_v;
    assign o_hit = r_res_h;

endmodule
